/* rtl/core/sdt_pkg.sv */
`default_nettype none

package sdt_pkg;

    localparam int NOTE_W  = 7;
    localparam int STEP_W  = 4;
    localparam int KEY_W   = 4;
    localparam int TC_W    = 4;
    localparam int OFFS_W  = 48;
    localparam int OUT_W   = 9;
    localparam int TONE_W  = 4;
    localparam int N_W     = 5;
    localparam int OCT_W   = 5;
    localparam int DIV_W   = 5;
    localparam int OFF_W   = 4;
    localparam int CFG_IDX_W = 2;

    localparam int SCALE_SLOTS = 12;
    localparam int OCT_SEMIS   = 12;

    // The note is biased by two octaves before the divide by twelve so that
    // the floor division works on a non-negative value.
    localparam int REL_W       = 8;
    localparam int REL_BIAS    = 24;
    localparam int RECIP_12    = 171;
    localparam int RECIP_SHIFT = 11;
    localparam int PROD_W      = 15;

    localparam logic [CFG_IDX_W-1:0] REG_KEY        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_OFFS = 2'd2;

    localparam logic [KEY_W-1:0]  KEY_RESET   = 4'd0;
    localparam logic [TC_W-1:0]   TC_RESET    = 4'd7;
    localparam logic [OFFS_W-1:0] OFFS_RESET  = 48'h0000_0B97_5420;

    typedef struct packed {
        logic [TONE_W-1:0]        best_i;
        logic [1:0]               best_o;
        logic signed [OCT_W-1:0]  oct;
        logic signed [STEP_W-1:0] steps;
        logic [N_W-1:0]           n;
        logic                     chrom;
    } snap_t;

    typedef struct packed {
        logic signed [OCT_W-1:0] koct;
        logic                    neg;
        logic                    chrom;
        logic [N_W-1:0]          n;
    } div_side_t;

    function automatic logic [OFF_W-1:0] tone_offset(
        input logic              chrom,
        input logic [TONE_W-1:0] idx,
        input logic [OFFS_W-1:0] offs
    );
        logic [OFF_W-1:0] res;
        res = '0;
        if (chrom) begin
            res = idx;
        end else begin
            for (int s = 0; s < SCALE_SLOTS; s++) begin
                if (idx == TONE_W'(s)) begin
                    res = offs[OFF_W*s +: OFF_W];
                end
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/sdt_snap.sv */
`default_nettype none

module sdt_snap #(
    parameter int MAX_TONES = 12
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [sdt_pkg::KEY_W-1:0]    key,
    input  wire logic [sdt_pkg::TC_W-1:0]     tone_count,
    input  wire logic [sdt_pkg::OFFS_W-1:0]   scale_offsets,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [sdt_pkg::NOTE_W-1:0]   in_base,
    input  wire logic [sdt_pkg::STEP_W-1:0]   in_steps,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output sdt_pkg::snap_t                    out_snap
);
    import sdt_pkg::*;

    // The chromatic scale always has twelve tones, so there are at least twelve lanes.
    localparam int LANES = (MAX_TONES > OCT_SEMIS) ? MAX_TONES : OCT_SEMIS;
    localparam int TREE  = 1 << $clog2(LANES);
    localparam int D_W   = 5;
    localparam int KEY_BITS = D_W + 1;

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    // Stage 1: scale size, octave and pitch class of the note relative to the key.
    logic signed [OCT_W-1:0]  s1_oct_reg, s1_oct_next;
    logic [OFF_W-1:0]         s1_pc_reg, s1_pc_next;
    logic signed [STEP_W-1:0] s1_steps_reg;
    logic [N_W-1:0]           s1_n_reg, s1_n_next;
    logic                     s1_chrom_reg, s1_chrom_next;

    // Stage 2: nearest octave copy of every scale tone.
    logic [D_W-1:0]           s2_d_reg     [LANES];
    logic [D_W-1:0]           s2_d_next    [LANES];
    logic [1:0]               s2_o_reg     [LANES];
    logic [1:0]               s2_o_next    [LANES];
    logic                     s2_ok_reg    [LANES];
    logic                     s2_ok_next   [LANES];
    logic signed [OCT_W-1:0]  s2_oct_reg;
    logic signed [STEP_W-1:0] s2_steps_reg;
    logic [N_W-1:0]           s2_n_reg;
    logic                     s2_chrom_reg;

    // Stage 3: first minimum over all lanes.
    snap_t s3_snap_reg, s3_snap_next;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb begin
        logic [REL_W-1:0]  rel;
        logic [PROD_W-1:0] prod;
        logic [3:0]        q;
        rel  = REL_W'(in_base) + REL_W'(REL_BIAS) - REL_W'(key);
        prod = PROD_W'(rel) * PROD_W'(RECIP_12);
        q    = prod[PROD_W-1:RECIP_SHIFT];
        s1_oct_next = $signed({1'b0, q}) - OCT_W'(2);
        s1_pc_next  = OFF_W'(rel - REL_W'(q) * REL_W'(OCT_SEMIS));
        if (tone_count == '0) begin
            s1_n_next     = N_W'(OCT_SEMIS);
            s1_chrom_next = 1'b1;
        end else begin
            s1_chrom_next = 1'b0;
            if ({1'b0, tone_count} > N_W'(MAX_TONES)) begin
                s1_n_next = N_W'(MAX_TONES);
            end else begin
                s1_n_next = {1'b0, tone_count};
            end
        end
    end

    always_comb begin
        logic [OFF_W-1:0]  off;
        logic signed [6:0] dm, dz, dp;
        logic [D_W-1:0]    am, az, ap, best;
        logic [1:0]        bo;
        for (int i = 0; i < LANES; i++) begin
            off  = tone_offset(s1_chrom_reg, TONE_W'(i), scale_offsets);
            dz   = $signed({3'b0, off}) - $signed({3'b0, s1_pc_reg});
            dm   = dz - 7'sd12;
            dp   = dz + 7'sd12;
            am   = dm[6] ? D_W'(-dm) : D_W'(dm);
            az   = dz[6] ? D_W'(-dz) : D_W'(dz);
            ap   = dp[6] ? D_W'(-dp) : D_W'(dp);
            // Octave below first, then same octave, then above; ties keep the earlier one.
            best = am;
            bo   = 2'd0;
            if (az < best) begin
                best = az;
                bo   = 2'd1;
            end
            if (ap < best) begin
                best = ap;
                bo   = 2'd2;
            end
            s2_d_next[i]  = best;
            s2_o_next[i]  = bo;
            s2_ok_next[i] = (N_W'(i) < s1_n_reg);
        end
    end

    always_comb begin
        logic [KEY_BITS-1:0] nk [2*TREE];
        logic [TONE_W-1:0]   ni [2*TREE];
        logic [1:0]          no [2*TREE];
        for (int j = 0; j < 2*TREE; j++) begin
            nk[j] = '1;
            ni[j] = '0;
            no[j] = '0;
        end
        for (int i = 0; i < TREE; i++) begin
            ni[TREE+i] = TONE_W'(i);
            if (i < LANES) begin
                nk[TREE+i] = {!s2_ok_reg[i], s2_d_reg[i]};
                no[TREE+i] = s2_o_reg[i];
            end
        end
        // Lower lane index wins a tie, which matches a first-found scan.
        for (int j = TREE - 1; j >= 1; j--) begin
            if (nk[2*j] <= nk[2*j+1]) begin
                nk[j] = nk[2*j];
                ni[j] = ni[2*j];
                no[j] = no[2*j];
            end else begin
                nk[j] = nk[2*j+1];
                ni[j] = ni[2*j+1];
                no[j] = no[2*j+1];
            end
        end
        s3_snap_next.best_i = ni[1];
        s3_snap_next.best_o = no[1];
        s3_snap_next.oct    = s2_oct_reg;
        s3_snap_next.steps  = s2_steps_reg;
        s3_snap_next.n      = s2_n_reg;
        s3_snap_next.chrom  = s2_chrom_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= in_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_oct_reg   <= s1_oct_next;
            s1_pc_reg    <= s1_pc_next;
            s1_steps_reg <= in_steps;
            s1_n_reg     <= s1_n_next;
            s1_chrom_reg <= s1_chrom_next;
        end
        if (en2) begin
            for (int i = 0; i < LANES; i++) begin
                s2_d_reg[i]  <= s2_d_next[i];
                s2_o_reg[i]  <= s2_o_next[i];
                s2_ok_reg[i] <= s2_ok_next[i];
            end
            s2_oct_reg   <= s1_oct_reg;
            s2_steps_reg <= s1_steps_reg;
            s2_n_reg     <= s1_n_reg;
            s2_chrom_reg <= s1_chrom_reg;
        end
        if (en3) begin
            s3_snap_reg <= s3_snap_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_snap  = s3_snap_reg;

endmodule

`default_nettype wire

/* rtl/core/sdt_div.sv */
`default_nettype none

module sdt_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [sdt_pkg::DIV_W-1:0]   in_dividend,
    input  wire sdt_pkg::div_side_t          in_side,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [sdt_pkg::DIV_W-1:0]        out_quot,
    output logic [sdt_pkg::N_W-1:0]          out_rem,
    output sdt_pkg::div_side_t               out_side
);
    import sdt_pkg::*;

    // Restoring division, one quotient bit per stage, divisor taken from in_side.n.
    logic              v_reg    [DIV_W];
    logic              en       [DIV_W];
    logic [N_W-1:0]    rem_reg  [DIV_W];
    logic [N_W-1:0]    rem_next [DIV_W];
    logic [DIV_W-1:0]  quot_reg [DIV_W];
    logic [DIV_W-1:0]  quot_next[DIV_W];
    logic [DIV_W-1:0]  dvd_reg  [DIV_W];
    logic [DIV_W-1:0]  dvd_next [DIV_W];
    div_side_t         side_reg [DIV_W];
    div_side_t         side_next[DIV_W];

    always_comb begin
        for (int s = DIV_W - 1; s >= 0; s--) begin
            if (s == DIV_W - 1) begin
                en[s] = !v_reg[s] || out_ready;
            end else begin
                en[s] = !v_reg[s] || en[s+1];
            end
        end
    end

    assign in_ready = en[0];

    always_comb begin
        logic [N_W-1:0]   rem_in;
        logic [DIV_W-1:0] quot_in;
        logic [N_W:0]     trial;
        logic             ge;
        for (int s = 0; s < DIV_W; s++) begin
            if (s == 0) begin
                rem_in       = '0;
                quot_in      = '0;
                dvd_next[s]  = in_dividend;
                side_next[s] = in_side;
            end else begin
                rem_in       = rem_reg[s-1];
                quot_in      = quot_reg[s-1];
                dvd_next[s]  = dvd_reg[s-1];
                side_next[s] = side_reg[s-1];
            end
            trial = {rem_in, dvd_next[s][DIV_W-1-s]};
            ge    = (trial >= {1'b0, side_next[s].n});
            if (ge) begin
                rem_next[s] = N_W'(trial - {1'b0, side_next[s].n});
            end else begin
                rem_next[s] = N_W'(trial);
            end
            quot_next[s] = {quot_in[DIV_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < DIV_W; s++) begin
                v_reg[s] <= 1'b0;
            end
        end else begin
            if (en[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int s = 1; s < DIV_W; s++) begin
                if (en[s]) begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < DIV_W; s++) begin
            if (en[s]) begin
                rem_reg[s]  <= rem_next[s];
                quot_reg[s] <= quot_next[s];
                dvd_reg[s]  <= dvd_next[s];
                side_reg[s] <= side_next[s];
            end
        end
    end

    assign out_valid = v_reg[DIV_W-1];
    assign out_quot  = quot_reg[DIV_W-1];
    assign out_rem   = rem_reg[DIV_W-1];
    assign out_side  = side_reg[DIV_W-1];

endmodule

`default_nettype wire

/* rtl/core/scale_degree_transpose_unit.sv */
// Scale degree transposer. Each input transaction carries a MIDI note and a
// signed number of scale degrees; each output transaction carries the note
// reached after snapping the input to the nearest tone of the configured scale
// (relative to the key) and stepping the given number of degrees.
// Channels: s_tdata = {degree_steps, base_note}, m_tdata = target_note as a
// 9-bit two's complement value. Every input transaction gives one output.
// The key, the tone count (zero means chromatic) and the packed table of
// semitone offsets are written through the cfg_wr_* port, one register per
// cycle. The user must write them only while no transaction is in flight;
// the block itself does not enforce this. Throughput is one transaction per
// cycle while m_tready is high. From input acceptance to m_tvalid there are
// three stages for the octave split, the per-tone distance lanes and the
// minimum tree, five for the bit-per-stage divide by the tone count and one
// for the output register. A stall on m_tready backs up one stage at a time;
// s_tready drops only once every stage holds a transaction. Nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and loads a C major
// scale: key 0, seven tones.
`default_nettype none

module scale_degree_transpose_unit #(
    parameter int MAX_TONES = 12
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input transactions.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [15:0]                    s_tdata,   // base_note[6:0], degree_steps[10:7]
    // Output transactions.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [15:0]                         m_tdata,   // target_note[8:0]
    // Register writes.
    input  wire logic                           cfg_wr_en,
    input  wire logic [sdt_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [sdt_pkg::OFFS_W-1:0]     cfg_wr_data
);
    import sdt_pkg::*;

    localparam int KO_W  = 7;
    localparam int RES_W = 11;

    logic [KEY_W-1:0]  key_reg;
    logic [TC_W-1:0]   tone_count_reg;
    logic [OFFS_W-1:0] scale_offsets_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg           <= KEY_RESET;
            tone_count_reg    <= TC_RESET;
            scale_offsets_reg <= OFFS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_KEY:        key_reg           <= cfg_wr_data[KEY_W-1:0];
                REG_TONE_COUNT: tone_count_reg    <= cfg_wr_data[TC_W-1:0];
                REG_SCALE_OFFS: scale_offsets_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    logic      snap_valid, snap_ready;
    snap_t     snap;

    sdt_snap #(
        .MAX_TONES (MAX_TONES)
    ) u_snap (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .key           (key_reg),
        .tone_count    (tone_count_reg),
        .scale_offsets (scale_offsets_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_base       (s_tdata[NOTE_W-1:0]),
        .in_steps      (s_tdata[NOTE_W +: STEP_W]),
        .out_valid     (snap_valid),
        .out_ready     (snap_ready),
        .out_snap      (snap)
    );

    // Split the degree position: (oct + o - 1) * n + i + steps. The octave part is
    // kept aside and only i + steps is divided by n.
    logic signed [5:0]  t;
    logic [DIV_W-1:0]   dvd;
    div_side_t          side;

    always_comb begin
        t         = $signed({2'b0, snap.best_i}) + 6'(snap.steps);
        side.koct = snap.oct + $signed({3'b0, snap.best_o}) - OCT_W'(1);
        side.neg  = t[5];
        side.chrom = snap.chrom;
        side.n    = snap.n;
        // For a negative value the floor divide works on -t-1.
        dvd       = t[5] ? DIV_W'(~t) : DIV_W'(t);
    end

    logic              div_valid, div_ready;
    logic [DIV_W-1:0]  div_quot;
    logic [N_W-1:0]    div_rem;
    div_side_t         div_side;

    sdt_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (snap_valid),
        .in_ready    (snap_ready),
        .in_dividend (dvd),
        .in_side     (side),
        .out_valid   (div_valid),
        .out_ready   (div_ready),
        .out_quot    (div_quot),
        .out_rem     (div_rem),
        .out_side    (div_side)
    );

    logic               m_tvalid_reg;
    logic [OUT_W-1:0]   target_reg, target_next;
    logic               out_en;

    assign out_en    = !m_tvalid_reg || m_tready;
    assign div_ready = out_en;

    always_comb begin
        logic signed [KO_W-1:0]  ko_add, ko;
        logic [N_W-1:0]          ki_full;
        logic [OFF_W-1:0]        off;
        logic signed [RES_W-1:0] res;
        if (div_side.neg) begin
            ko_add  = ~$signed({2'b0, div_quot});
            ki_full = div_side.n - N_W'(1) - div_rem;
        end else begin
            ko_add  = $signed({2'b0, div_quot});
            ki_full = div_rem;
        end
        ko  = KO_W'(div_side.koct) + ko_add;
        off = tone_offset(div_side.chrom, ki_full[TONE_W-1:0], scale_offsets_reg);
        res = $signed({7'b0, key_reg}) + RES_W'(ko) * RES_W'(OCT_SEMIS)
            + $signed({7'b0, off});
        target_next = res[OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_en) begin
            m_tvalid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            target_reg <= target_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(16 - OUT_W){1'b0}}, target_reg};

endmodule

`default_nettype wire
